// ----- src/cll_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cll_pkg
// Shared types, token codes and keyword table for the C-like lexer.
// ----------------------------------------------------------------------------
package cll_pkg;

    localparam int POS_W       = 16;
    localparam int KW_CHARS    = 8;
    localparam int PREFIX_W    = 8 * KW_CHARS;
    localparam int KW_COUNT    = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_IDENT  = 6'd1;
    localparam logic [5:0] K_NUM    = 6'd2;
    localparam logic [5:0] K_STR    = 6'd3;
    localparam logic [5:0] K_SBYTE  = 6'd4;
    localparam logic [5:0] K_KW0    = 6'd5;
    localparam logic [5:0] K_PLUS   = 6'd16;
    localparam logic [5:0] K_MINUS  = 6'd17;
    localparam logic [5:0] K_MUL    = 6'd18;
    localparam logic [5:0] K_DIV    = 6'd19;
    localparam logic [5:0] K_MOD    = 6'd20;
    localparam logic [5:0] K_ASSIGN = 6'd21;
    localparam logic [5:0] K_EQEQ   = 6'd22;
    localparam logic [5:0] K_SEMI   = 6'd23;
    localparam logic [5:0] K_LPAR   = 6'd24;
    localparam logic [5:0] K_RPAR   = 6'd25;
    localparam logic [5:0] K_LBR    = 6'd26;
    localparam logic [5:0] K_RBR    = 6'd27;
    localparam logic [5:0] K_COMMA  = 6'd28;
    localparam logic [5:0] K_GT     = 6'd29;
    localparam logic [5:0] K_GE     = 6'd30;
    localparam logic [5:0] K_LT     = 6'd31;
    localparam logic [5:0] K_LE     = 6'd32;
    localparam logic [5:0] K_NOT    = 6'd33;
    localparam logic [5:0] K_NE     = 6'd34;
    localparam logic [5:0] K_ANDAND = 6'd35;
    localparam logic [5:0] K_OROR   = 6'd36;
    localparam logic [5:0] K_EBAD   = 6'd37;
    localparam logic [5:0] K_ESTR   = 6'd38;
    localparam logic [5:0] K_ECOM   = 6'd39;

    localparam logic [PREFIX_W-1:0] KW_WORD [KW_COUNT] = '{
        PREFIX_W'(64'h696e74),
        PREFIX_W'(64'h737472696e67),
        PREFIX_W'(64'h7072696e74),
        PREFIX_W'(64'h6966),
        PREFIX_W'(64'h656c7365),
        PREFIX_W'(64'h7768696c65),
        PREFIX_W'(64'h666f72),
        PREFIX_W'(64'h627265616b),
        PREFIX_W'(64'h636f6e74696e7565),
        PREFIX_W'(64'h72657475726e),
        PREFIX_W'(64'h66756e63)
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd6, 4'd5, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8, 4'd6, 4'd4
    };

    typedef enum logic [15:0] {
        M_START = 16'h0001,
        M_IDENT = 16'h0002,
        M_NUM   = 16'h0004,
        M_STR   = 16'h0008,
        M_ESC   = 16'h0010,
        M_SLASH = 16'h0020,
        M_LINE  = 16'h0040,
        M_BLOCK = 16'h0080,
        M_BSTAR = 16'h0100,
        M_EQ    = 16'h0200,
        M_GT    = 16'h0400,
        M_LT    = 16'h0800,
        M_BANG  = 16'h1000,
        M_AMP   = 16'h2000,
        M_PIPE  = 16'h4000,
        M_ERR   = 16'h8000
    } t_mode;

    typedef struct packed {
        logic [5:0]       kind;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] len;
        logic [7:0]       val;
    } t_res;

    typedef struct packed {
        t_res res0;
        t_res res1;
        logic two;
    } t_entry;

    function automatic logic [5:0] kw_kind(input logic [PREFIX_W-1:0] prefix,
                                           input logic [3:0] wlen);
        logic [5:0] kind;
        kind = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (wlen == KW_LEN[i] && prefix == KW_WORD[i]) begin
                kind = K_KW0 + 6'(i);
            end
        end
        return kind;
    endfunction

endpackage
`default_nettype wire

// ----- src/cll_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cll_front
// Lexer state machine: classifies one byte per transfer into zero, one or
// two result records and pushes them into the result queue.
// ----------------------------------------------------------------------------
module cll_front import cll_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire logic   i_full,
    input  wire logic   i_kind,
    input  wire logic   [7:0] i_char_byte,
    output logic        o_push,
    output t_entry      o_entry
);

    typedef struct packed {
        t_mode      mode;
        logic       is_open;
        logic       emit;
        logic [5:0] kind;
    } t_sb;

    t_mode              r_mode, n_mode;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_tstart, n_tstart;
    logic [PREFIX_W-1:0] r_prefix, n_prefix;
    logic [3:0]         r_wlen, n_wlen;

    logic               accept;
    logic [7:0]         c;
    t_sb                sb;
    logic               use_sb;
    logic [1:0]         cnt;
    t_res               res [2];
    logic [POS_W-1:0]   span0;
    logic [POS_W:0]     span1_raw;
    logic [POS_W-1:0]   span1;
    logic               is_alpha, is_digit;

    function automatic t_res tok(input logic [5:0] kind, input logic [POS_W-1:0] start,
                                 input logic [POS_W-1:0] len, input logic [7:0] val);
        t_res r;
        r.kind  = kind;
        r.start = start;
        r.len   = len;
        r.val   = val;
        return r;
    endfunction

    function automatic t_sb start_byte(input logic [7:0] ch);
        t_sb s;
        s.mode    = M_START;
        s.is_open = 1'b0;
        s.emit    = 1'b0;
        s.kind    = K_EOF;
        if (ch == " " || ch == 8'h09 || ch == 8'h0a) begin
            s.mode = M_START;
        end else if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) begin
            s.mode = M_IDENT; s.is_open = 1'b1;
        end else if (ch >= "0" && ch <= "9") begin
            s.mode = M_NUM; s.is_open = 1'b1;
        end else begin
            priority case (ch)
                8'h22: begin s.mode = M_STR;   s.is_open = 1'b1; end
                "/":   begin s.mode = M_SLASH; s.is_open = 1'b1; end
                "=":   begin s.mode = M_EQ;    s.is_open = 1'b1; end
                ">":   begin s.mode = M_GT;    s.is_open = 1'b1; end
                "<":   begin s.mode = M_LT;    s.is_open = 1'b1; end
                "!":   begin s.mode = M_BANG;  s.is_open = 1'b1; end
                "&":   begin s.mode = M_AMP;   s.is_open = 1'b1; end
                "|":   begin s.mode = M_PIPE;  s.is_open = 1'b1; end
                "+":   begin s.emit = 1'b1; s.kind = K_PLUS;  end
                "-":   begin s.emit = 1'b1; s.kind = K_MINUS; end
                "*":   begin s.emit = 1'b1; s.kind = K_MUL;   end
                "%":   begin s.emit = 1'b1; s.kind = K_MOD;   end
                ";":   begin s.emit = 1'b1; s.kind = K_SEMI;  end
                "(":   begin s.emit = 1'b1; s.kind = K_LPAR;  end
                ")":   begin s.emit = 1'b1; s.kind = K_RPAR;  end
                "{":   begin s.emit = 1'b1; s.kind = K_LBR;   end
                "}":   begin s.emit = 1'b1; s.kind = K_RBR;   end
                ",":   begin s.emit = 1'b1; s.kind = K_COMMA; end
                default: begin
                    s.emit = 1'b1; s.kind = K_EBAD; s.mode = M_ERR;
                end
            endcase
        end
        return s;
    endfunction

    assign accept    = i_valid && !i_full;
    assign c         = i_char_byte;
    assign sb        = start_byte(c);
    assign span0     = r_pos - r_tstart;
    assign span1_raw = {1'b0, span0} + {{POS_W{1'b0}}, 1'b1};
    assign span1     = span1_raw[POS_W] ? POS_MAX : span1_raw[POS_W-1:0];
    assign is_alpha  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_digit  = (c >= "0" && c <= "9");

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_prefix = r_prefix;
        n_wlen   = r_wlen;
        use_sb   = 1'b0;
        cnt      = 2'd0;
        res[0]   = '0;
        res[1]   = '0;

        if (i_kind || c == 8'h00) begin
            unique case (r_mode)
                M_IDENT: begin
                    res[0] = tok(kw_kind(r_prefix, r_wlen), r_tstart, span0, 8'h00);
                    cnt = 2'd1;
                end
                M_NUM: begin
                    res[0] = tok(K_NUM, r_tstart, span0, 8'h00); cnt = 2'd1;
                end
                M_STR, M_ESC: begin
                    res[0] = tok(K_ESTR, r_tstart, span0, 8'h00); cnt = 2'd1;
                end
                M_SLASH: begin
                    res[0] = tok(K_DIV, r_tstart, POS_W'(1), 8'h00); cnt = 2'd1;
                end
                M_BLOCK, M_BSTAR: begin
                    res[0] = tok(K_ECOM, r_tstart, span0, 8'h00); cnt = 2'd1;
                end
                M_EQ: begin
                    res[0] = tok(K_ASSIGN, r_tstart, POS_W'(1), 8'h00); cnt = 2'd1;
                end
                M_GT: begin
                    res[0] = tok(K_GT, r_tstart, POS_W'(1), 8'h00); cnt = 2'd1;
                end
                M_LT: begin
                    res[0] = tok(K_LT, r_tstart, POS_W'(1), 8'h00); cnt = 2'd1;
                end
                M_BANG: begin
                    res[0] = tok(K_NOT, r_tstart, POS_W'(1), 8'h00); cnt = 2'd1;
                end
                M_AMP, M_PIPE: begin
                    res[0] = tok(K_EBAD, r_tstart, POS_W'(1), 8'h00); cnt = 2'd1;
                end
                default: begin
                    cnt = 2'd0;
                end
            endcase
            res[cnt[0]] = tok(K_EOF, r_pos, '0, 8'h00);
            cnt      = cnt + 2'd1;
            n_mode   = M_START;
            n_pos    = '0;
            n_tstart = '0;
            n_prefix = '0;
            n_wlen   = '0;
        end else begin
            unique case (r_mode)
                M_START: use_sb = 1'b1;
                M_IDENT: begin
                    if (is_alpha || is_digit || c == "_") begin
                        if (r_wlen < 4'(KW_CHARS)) begin
                            n_prefix = {r_prefix[PREFIX_W-9:0], c};
                        end
                        if (r_wlen != 4'd15) begin
                            n_wlen = r_wlen + 4'd1;
                        end
                    end else begin
                        res[0] = tok(kw_kind(r_prefix, r_wlen), r_tstart, span0, 8'h00);
                        cnt    = 2'd1;
                        use_sb = 1'b1;
                    end
                end
                M_NUM: begin
                    if (!is_digit) begin
                        res[0] = tok(K_NUM, r_tstart, span0, 8'h00);
                        cnt    = 2'd1;
                        use_sb = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == 8'h22) begin
                        res[0] = tok(K_STR, r_tstart, span1, 8'h00);
                        cnt    = 2'd1;
                        n_mode = M_START;
                    end else if (c == 8'h5c) begin
                        n_mode = M_ESC;
                    end else begin
                        res[0] = tok(K_SBYTE, r_pos, POS_W'(1), c);
                        cnt    = 2'd1;
                    end
                end
                M_ESC: begin
                    res[0] = tok(K_SBYTE, (r_pos != '0) ? r_pos - POS_W'(1) : '0,
                                 POS_W'(2),
                                 (c == "n") ? 8'h0a : ((c == "t") ? 8'h09 : c));
                    cnt    = 2'd1;
                    n_mode = M_STR;
                end
                M_SLASH: begin
                    if (c == "/") begin
                        n_mode = M_LINE;
                    end else if (c == "*") begin
                        n_mode = M_BLOCK;
                    end else begin
                        res[0] = tok(K_DIV, r_tstart, POS_W'(1), 8'h00);
                        cnt    = 2'd1;
                        use_sb = 1'b1;
                    end
                end
                M_LINE: begin
                    if (c == 8'h0a) n_mode = M_START;
                end
                M_BLOCK: begin
                    if (c == "*") n_mode = M_BSTAR;
                end
                M_BSTAR: begin
                    if (c == "/") begin
                        n_mode = M_START;
                    end else if (c != "*") begin
                        n_mode = M_BLOCK;
                    end
                end
                M_EQ, M_GT, M_LT, M_BANG: begin
                    cnt = 2'd1;
                    if (c == "=") begin
                        n_mode = M_START;
                        res[0] = tok((r_mode == M_EQ) ? K_EQEQ :
                                     (r_mode == M_GT) ? K_GE :
                                     (r_mode == M_LT) ? K_LE : K_NE,
                                     r_tstart, span1, 8'h00);
                    end else begin
                        use_sb = 1'b1;
                        res[0] = tok((r_mode == M_EQ) ? K_ASSIGN :
                                     (r_mode == M_GT) ? K_GT :
                                     (r_mode == M_LT) ? K_LT : K_NOT,
                                     r_tstart, POS_W'(1), 8'h00);
                    end
                end
                M_AMP, M_PIPE: begin
                    cnt = 2'd1;
                    if (c == ((r_mode == M_AMP) ? "&" : "|")) begin
                        res[0] = tok((r_mode == M_AMP) ? K_ANDAND : K_OROR,
                                     r_tstart, span1, 8'h00);
                        n_mode = M_START;
                    end else begin
                        res[0] = tok(K_EBAD, r_tstart, POS_W'(1), 8'h00);
                        n_mode = M_ERR;
                    end
                end
                M_ERR: n_mode = M_ERR;
                default: use_sb = 1'b1;
            endcase

            if (use_sb) begin
                n_mode = sb.mode;
                if (sb.is_open) begin
                    n_tstart = r_pos;
                end
                if (sb.mode == M_IDENT) begin
                    n_prefix = {{(PREFIX_W-8){1'b0}}, c};
                    n_wlen   = 4'd1;
                end
                if (sb.emit) begin
                    res[cnt[0]] = tok(sb.kind, r_pos, POS_W'(1), 8'h00);
                    cnt = cnt + 2'd1;
                end
            end

            if (r_pos != POS_MAX) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    assign o_push       = accept && (cnt != 2'd0);
    assign o_entry.res0 = res[0];
    assign o_entry.res1 = res[1];
    assign o_entry.two  = cnt[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_START;
            r_pos    <= '0;
            r_tstart <= '0;
            r_prefix <= '0;
            r_wlen   <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_prefix <= n_prefix;
            r_wlen   <= n_wlen;
        end
    end

endmodule
`default_nettype wire

// ----- src/cll_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cll_queue
// Short FIFO of result records between the lexer front and the output side.
// ----------------------------------------------------------------------------
module cll_queue import cll_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_entry      o_entry
);

    t_entry                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wr, r_rd;
    logic [QUEUE_AW:0]      r_cnt, n_cnt;
    logic                   do_push, do_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (QUEUE_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wr <= r_wr + QUEUE_AW'(1);
            if (do_pop)  r_rd <= r_rd + QUEUE_AW'(1);
        end
    end

endmodule
`default_nettype wire

// ----- src/cll_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cll_back
// Output side: unpacks queued records one result per transfer into the
// output register and marks the last result of each input byte.
// ----------------------------------------------------------------------------
module cll_back import cll_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  t_entry      i_q_entry,
    output logic        o_pop,
    input  wire logic   i_stall,
    output logic        o_valid,
    output t_res        o_res,
    output logic        o_last
);

    logic   r_valid;
    logic   r_sel;
    t_res   r_res;
    logic   r_last;
    logic   load;

    assign load    = !r_valid || !i_stall;
    assign o_pop   = load && i_q_valid && (r_sel || !i_q_entry.two);
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_res  <= r_sel ? i_q_entry.res1 : i_q_entry.res0;
            r_last <= r_sel || !i_q_entry.two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_sel <= !r_sel && i_q_entry.two;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/c_like_lexer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_like_lexer_top
// Streaming tokenizer for a small C-like language: lexer front, result
// queue and output register.
// ----------------------------------------------------------------------------
// Dataflow: the first result of a byte is written into the result queue at its
//   input transfer and then loaded into the output register.
// Throughput: one byte per cycle while o_stall is low; two results of a byte
//   leave one per output transfer, absorbed by the four-entry result queue.
// Reset: synchronous, active low; clears lexer mode, position, queue and
//   output valid.
// ----------------------------------------------------------------------------
module c_like_lexer_top import cll_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_kind,
    input  wire logic [7:0]         i_char_byte,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [5:0]              o_token_kind,
    output logic [POS_W-1:0]        o_start_pos,
    output logic [POS_W-1:0]        o_span_len,
    output logic [7:0]              o_value_byte,
    output logic                    o_last
);

    logic   full;
    logic   push;
    t_entry push_entry;
    logic   q_valid;
    t_entry q_entry;
    logic   pop;
    t_res   out_res;

    assign o_stall = full;

    cll_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_full      (full),
        .i_kind      (i_kind),
        .i_char_byte (i_char_byte),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    cll_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    cll_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_res     (out_res),
        .o_last    (o_last)
    );

    assign o_token_kind = out_res.kind;
    assign o_start_pos  = out_res.start;
    assign o_span_len   = out_res.len;
    assign o_value_byte = out_res.val;

endmodule
`default_nettype wire
